// ===== hw/rtl/srdg_pkg.sv =====
// Shared definitions for the subarray row descriptor generator.
// Register map and field widths; no dependencies.
package srdg_pkg;

  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] RegExtentMid   = 4'd0;
  localparam logic [CfgIdxW-1:0] RegExtentInner = 4'd1;
  localparam logic [CfgIdxW-1:0] RegStartOuter  = 4'd2;
  localparam logic [CfgIdxW-1:0] RegStartMid    = 4'd3;
  localparam logic [CfgIdxW-1:0] RegStartInner  = 4'd4;
  localparam logic [CfgIdxW-1:0] RegSizeOuter   = 4'd5;
  localparam logic [CfgIdxW-1:0] RegSizeMid     = 4'd6;
  localparam logic [CfgIdxW-1:0] RegSizeInner   = 4'd7;

  localparam int unsigned EpochW   = 32;
  localparam int unsigned ArrayIdW = 16;
  localparam int unsigned OffsetW  = 50;
  localparam int unsigned RowBytesW = 22;

  // shared multiplier operand widths
  localparam int unsigned MulAW = 17;
  localparam int unsigned MulBW = 33;

endpackage

// ===== hw/rtl/subarray_row_descriptor_generator_top.sv =====
// Subarray row descriptor generator: one descriptor per inner row of a local block.
// Uses srdg_pkg for the register map and widths.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------------------
//  in      | sink      | in_valid_i/in_stall_o | request_epoch_i, array_id_i
//  out     | source    | out_valid_o/out_stall_i | out_epoch_o, out_array_id_o, offsets,
//          |           |                       | row_bytes_o, last_row_o
//  cfg     | sink      | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// From accept to the output register each word makes five passes through one
// shared 17x33 multiplier (plane size, mid term, outer term, local row, local
// offset) and then a load step. No new word is taken until the last one is loaded:
// the input stalls while a word is in flight. The output register lets the next
// word start while a descriptor waits. Reset clears the row counters and loads the
// register reset values. An output stall holds the load step.
module subarray_row_descriptor_generator_top #(
  parameter int unsigned NUM_DIMS   = 3,
  parameter int unsigned ELEM_BYTES = 4
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [srdg_pkg::EpochW-1:0]       request_epoch_i,
  input  logic [srdg_pkg::ArrayIdW-1:0]     array_id_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [srdg_pkg::EpochW-1:0]       out_epoch_o,
  output logic [srdg_pkg::ArrayIdW-1:0]     out_array_id_o,
  output logic [srdg_pkg::OffsetW-1:0]      global_byte_offset_o,
  output logic [srdg_pkg::RowBytesW-1:0]    row_bytes_o,
  output logic [srdg_pkg::OffsetW-1:0]      local_byte_offset_o,
  output logic                              last_row_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [srdg_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [srdg_pkg::CfgDataW-1:0]     cfg_data_i
);

  localparam int unsigned OffW = srdg_pkg::OffsetW;
  localparam int unsigned AW   = srdg_pkg::MulAW;
  localparam int unsigned BW   = srdg_pkg::MulBW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_M0   = 3'd1;
  localparam logic [2:0] S_M1   = 3'd2;
  localparam logic [2:0] S_M2   = 3'd3;
  localparam logic [2:0] S_M3   = 3'd4;
  localparam logic [2:0] S_M4   = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  // configuration registers
  logic [15:0] ext_mid_q, ext_inner_q, st_outer_q, st_mid_q, st_inner_q;
  logic [15:0] bs_outer_q, bs_mid_q, bs_inner_q;

  logic [15:0] row_outer_q, row_outer_d, row_mid_q, row_mid_d;
  logic [2:0]  state_q, state_d;

  logic [srdg_pkg::EpochW-1:0]   epoch_q;
  logic [srdg_pkg::ArrayIdW-1:0] aid_q;

  logic [31:0]     plane_q;
  logic [OffW-1:0] prod_q, prod_d;
  logic [OffW-1:0] gacc_q, gacc_d;

  logic [AW-1:0]   mul_a;
  logic [BW-1:0]   mul_b;
  logic [OffW-1:0] mul_p;

  logic            out_valid_q;
  logic [srdg_pkg::EpochW-1:0]    out_epoch_q;
  logic [srdg_pkg::ArrayIdW-1:0]  out_aid_q;
  logic [OffW-1:0]                gbo_q, lbo_q;
  logic [srdg_pkg::RowBytesW-1:0] row_bytes_q;
  logic                           last_q;

  // effective geometry for the configured number of dimensions
  logic [15:0] st_outer_e, st_mid_e, bs_outer_e, bs_mid_e, io_e, im_e;
  logic        wrap_mid, wrap_outer, out_free, load;

  always_comb begin
    st_outer_e = (NUM_DIMS < 3) ? 16'd0 : st_outer_q;
    bs_outer_e = (NUM_DIMS < 3) ? 16'd1 : bs_outer_q;
    io_e       = (NUM_DIMS < 3) ? 16'd0 : row_outer_q;
    st_mid_e   = (NUM_DIMS < 2) ? 16'd0 : st_mid_q;
    bs_mid_e   = (NUM_DIMS < 2) ? 16'd1 : bs_mid_q;
    im_e       = (NUM_DIMS < 2) ? 16'd0 : row_mid_q;
  end

  assign wrap_mid   = ({1'b0, im_e} + 17'd1) >= {1'b0, bs_mid_e};
  assign wrap_outer = ({1'b0, io_e} + 17'd1) >= {1'b0, bs_outer_e};

  assign out_free = !out_valid_q || !out_stall_i;
  assign load     = (state_q == S_DONE) && out_free;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_M0: begin
        mul_a = {1'b0, ext_mid_q};
        mul_b = {17'd0, ext_inner_q};
      end
      S_M1: begin
        mul_a = {1'b0, st_mid_e} + {1'b0, im_e};
        mul_b = {17'd0, ext_inner_q};
      end
      S_M2: begin
        mul_a = {1'b0, st_outer_e} + {1'b0, io_e};
        mul_b = {1'b0, plane_q};
      end
      S_M3: begin
        mul_a = {1'b0, io_e};
        mul_b = {17'd0, bs_mid_e};
      end
      S_M4: begin
        // local row index: io * bs_mid + im stays below 2^32
        mul_a = {1'b0, bs_inner_q};
        mul_b = prod_q[BW-1:0] + {17'd0, im_e};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = OffW'(mul_a) * OffW'(mul_b);

  always_comb begin
    state_d     = state_q;
    prod_d      = prod_q;
    gacc_d      = gacc_q;
    row_outer_d = row_outer_q;
    row_mid_d   = row_mid_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_M0;
      end
      S_M0: begin
        prod_d  = mul_p;
        state_d = S_M1;
      end
      S_M1: begin
        prod_d  = mul_p;
        state_d = S_M2;
      end
      S_M2: begin
        prod_d  = mul_p;
        gacc_d  = prod_q + {{(OffW-16){1'b0}}, st_inner_q};
        state_d = S_M3;
      end
      S_M3: begin
        prod_d  = mul_p;
        gacc_d  = gacc_q + prod_q;
        state_d = S_M4;
      end
      S_M4: begin
        prod_d  = mul_p;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
          if (!wrap_mid) begin
            row_mid_d = im_e + 16'd1;
          end else begin
            row_mid_d   = '0;
            row_outer_d = wrap_outer ? 16'd0 : io_e + 16'd1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_outer_q <= '0;
      row_mid_q   <= '0;
      out_valid_q <= 1'b0;
      ext_mid_q   <= 16'd1;
      ext_inner_q <= 16'd1;
      st_outer_q  <= 16'd0;
      st_mid_q    <= 16'd0;
      st_inner_q  <= 16'd0;
      bs_outer_q  <= 16'd1;
      bs_mid_q    <= 16'd1;
      bs_inner_q  <= 16'd1;
    end else begin
      state_q     <= state_d;
      row_outer_q <= row_outer_d;
      row_mid_q   <= row_mid_d;
      if (load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          srdg_pkg::RegExtentMid:   ext_mid_q   <= cfg_data_i;
          srdg_pkg::RegExtentInner: ext_inner_q <= cfg_data_i;
          srdg_pkg::RegStartOuter:  st_outer_q  <= cfg_data_i;
          srdg_pkg::RegStartMid:    st_mid_q    <= cfg_data_i;
          srdg_pkg::RegStartInner:  st_inner_q  <= cfg_data_i;
          srdg_pkg::RegSizeOuter:   bs_outer_q  <= cfg_data_i;
          srdg_pkg::RegSizeMid:     bs_mid_q    <= cfg_data_i;
          srdg_pkg::RegSizeInner:   bs_inner_q  <= cfg_data_i;
          default: ; // drop writes beyond the map
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    gacc_q <= gacc_d;
    if (state_q == S_IDLE && in_valid_i) begin
      epoch_q <= request_epoch_i;
      aid_q   <= array_id_i;
    end
    if (state_q == S_M1) plane_q <= prod_q[31:0];
    if (load) begin
      out_epoch_q <= epoch_q;
      out_aid_q   <= aid_q;
      gbo_q       <= gacc_q * OffW'(ELEM_BYTES);
      lbo_q       <= prod_q * OffW'(ELEM_BYTES);
      row_bytes_q <= srdg_pkg::RowBytesW'(bs_inner_q) * srdg_pkg::RowBytesW'(ELEM_BYTES);
      last_q      <= wrap_mid && wrap_outer;
    end
  end

  assign in_stall_o           = (state_q != S_IDLE);
  assign cfg_ready_o          = 1'b1;
  assign out_valid_o          = out_valid_q;
  assign out_epoch_o          = out_epoch_q;
  assign out_array_id_o       = out_aid_q;
  assign global_byte_offset_o = gbo_q;
  assign local_byte_offset_o  = lbo_q;
  assign row_bytes_o          = row_bytes_q;
  assign last_row_o           = last_q;

endmodule
